### rtl/core/psd_pkg.sv
// Shared constants and types for the point set diameter unit.
package psd_pkg;

    localparam int MAX_POINTS   = 128;
    localparam int COORD_W      = 24;
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int ABS_W        = COORD_W;
    localparam int SQ_W         = 2 * ABS_W + 1;
    localparam int ROOT_W       = (SQ_W + 1) / 2;
    localparam int DRAIN_CYCLES = 4;
    localparam int IN_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((ROOT_W + 7) / 8) * 8;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } psd_point_t;

    typedef struct packed {
        logic load;
        logic walk_start;
        logic walk_shift;
        logic reduce;
        logic clear;
    } psd_ctrl_t;

endpackage

### rtl/core/psd_cell.sv
// One cell of the point chain: stores a point, compares it with a passing point, keeps a maximum.
module psd_cell
    import psd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  psd_ctrl_t        ctrl,
    input  psd_point_t       stored_in,
    input  psd_point_t       moving_in,
    input  logic [SQ_W-1:0]  best_in,
    output psd_point_t       stored_out,
    output psd_point_t       moving_out,
    output logic [SQ_W-1:0]  best_out
);

    logic               sv_reg, sv_next;
    logic [COORD_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic               mv_reg, mv_next;
    logic [COORD_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic               v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic [ABS_W-1:0]   adx_reg, adx_next, ady_reg, ady_next;
    logic [2*ABS_W-1:0] sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SQ_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]    best_reg, best_next;
    logic [COORD_W:0]   dx, dy, dx_neg, dy_neg;

    always_comb
    begin
        sv_next = sv_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        if (ctrl.clear)
        begin
            sv_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            sv_next = stored_in.valid;
            sx_next = stored_in.x;
            sy_next = stored_in.y;
        end
    end

    always_comb
    begin
        mv_next = mv_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        if (ctrl.clear)
        begin
            mv_next = 1'b0;
        end
        else if (ctrl.walk_start)
        begin
            mv_next = sv_reg;
            mx_next = sx_reg;
            my_next = sy_reg;
        end
        else if (ctrl.walk_shift)
        begin
            mv_next = moving_in.valid;
            mx_next = moving_in.x;
            my_next = moving_in.y;
        end
    end

    always_comb
    begin
        dx       = {sx_reg[COORD_W-1], sx_reg} - {mx_reg[COORD_W-1], mx_reg};
        dy       = {sy_reg[COORD_W-1], sy_reg} - {my_reg[COORD_W-1], my_reg};
        dx_neg   = ~dx + 1'b1;
        dy_neg   = ~dy + 1'b1;
        adx_next = dx[COORD_W] ? dx_neg[ABS_W-1:0] : dx[ABS_W-1:0];
        ady_next = dy[COORD_W] ? dy_neg[ABS_W-1:0] : dy[ABS_W-1:0];
        v1_next  = sv_reg & mv_reg & ~ctrl.clear;
        sqx_next = adx_reg * adx_reg;
        sqy_next = ady_reg * ady_reg;
        v2_next  = v1_reg & ~ctrl.clear;
        sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        v3_next  = v2_reg & ~ctrl.clear;
    end

    always_comb
    begin
        best_next = best_reg;
        priority if (ctrl.clear)
        begin
            best_next = '0;
        end
        else if (ctrl.reduce)
        begin
            best_next = (best_in > best_reg) ? best_in : best_reg;
        end
        else if (v3_reg && (sum_reg > best_reg))
        begin
            best_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg   <= 1'b0;
            mv_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            sv_reg   <= sv_next;
            mv_reg   <= mv_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        adx_reg <= adx_next;
        ady_reg <= ady_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sum_reg <= sum_next;
    end

    assign stored_out = '{valid: sv_reg, x: sx_reg, y: sy_reg};
    assign moving_out = '{valid: mv_reg, x: mx_reg, y: my_reg};
    assign best_out   = best_reg;

endmodule

### rtl/core/psd_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module psd_sqrt
    import psd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int RAD_W  = 2 * ROOT_W;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W+1:0] rem_sh, trial;

    always_comb
    begin
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rad_next  = {{(RAD_W - SQ_W){1'b0}}, radicand};
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            step_next = step_reg + 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/point_set_diameter_unit.sv
// Top level of the point set diameter unit: point chain, sequencer, square root and output register.
//
//   group    direction  tdata                         side band
//   s_axis   in         x_coord[23:0], y_coord[47:24]  tlast = last_point
//   m_axis   out        max_distance[24:0], zero pad   tuser = points_dropped
//
// Points load into the cell chain at one item per cycle while the sequencer is in its load state.
// After the item with tlast the sequencer runs the pair walk over the stored points, the pipeline
// drain, the maximum collection along the chain and the bit-serial square root.
// A result waiting on m_axis holds off only the next set's end; points still load.
// Reset clears the point count, the drop flag and every cell.
module point_set_diameter_unit
    import psd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // x_coord, y_coord
    input  logic                  s_axis_tlast,   // last_point
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // max_distance, zero pad
    output logic                  m_axis_tuser    // points_dropped
);

    localparam logic [2:0] ST_LOAD       = 3'd0;
    localparam logic [2:0] ST_WSTART     = 3'd1;
    localparam logic [2:0] ST_WALK       = 3'd2;
    localparam logic [2:0] ST_DRAIN      = 3'd3;
    localparam logic [2:0] ST_REDUCE     = 3'd4;
    localparam logic [2:0] ST_ROOT_START = 3'd5;
    localparam logic [2:0] ST_ROOT       = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              overflow_reg, overflow_next;
    logic              drop_reg, drop_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0] out_dist_reg, out_dist_next;
    logic              out_drop_reg, out_drop_next;

    psd_ctrl_t         ctrl;
    logic              in_accept;
    logic              root_start;
    logic              root_done;
    logic [ROOT_W-1:0] root_value;
    logic              store_full;

    psd_point_t        stored_chain [0:MAX_POINTS];
    psd_point_t        moving_chain [0:MAX_POINTS];
    logic [SQ_W-1:0]   best_chain   [0:MAX_POINTS];

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign store_full    = (count_reg == CNT_W'(MAX_POINTS));

    assign stored_chain[0] = '{valid: 1'b1,
                               x: s_axis_tdata[COORD_W-1:0],
                               y: s_axis_tdata[2*COORD_W-1:COORD_W]};
    assign moving_chain[0] = '{valid: 1'b0, x: '0, y: '0};
    assign best_chain[0]   = '0;

    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cell
        psd_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .stored_in  (stored_chain[k]),
            .moving_in  (moving_chain[k]),
            .best_in    (best_chain[k]),
            .stored_out (stored_chain[k+1]),
            .moving_out (moving_chain[k+1]),
            .best_out   (best_chain[k+1])
        );
    end

    psd_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (best_chain[MAX_POINTS]),
        .done     (root_done),
        .root     (root_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        overflow_next  = overflow_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_dist_next  = out_dist_reg;
        out_drop_next  = out_drop_reg;
        ctrl           = '0;
        root_start     = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        drop_next  = overflow_reg | store_full;
                        state_next = ST_WSTART;
                    end
                end
            end
            ST_WSTART:
            begin
                ctrl.walk_start = 1'b1;
                step_next       = '0;
                state_next      = ST_WALK;
            end
            ST_WALK:
            begin
                if (step_reg == count_reg - 1'b1)
                begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ctrl.walk_shift = 1'b1;
                    step_next       = step_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(DRAIN_CYCLES - 1))
                begin
                    step_next  = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                ctrl.reduce = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == CNT_W'(MAX_POINTS - 2))
                begin
                    state_next = ST_ROOT_START;
                end
            end
            ST_ROOT_START:
            begin
                root_start    = 1'b1;
                ctrl.clear    = 1'b1;
                count_next    = '0;
                overflow_next = 1'b0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done && (!out_valid_reg || m_axis_tready))
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = root_value;
                    out_drop_next  = drop_reg;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            step_reg      <= '0;
            overflow_reg  <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            overflow_reg  <= overflow_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg <= out_dist_next;
        out_drop_reg <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - ROOT_W){1'b0}}, out_dist_reg};
    assign m_axis_tuser  = out_drop_reg;

endmodule
